[rtl/hotc_pkg.sv]
package hotc_pkg;

    // Modulus of the code reduction
    localparam logic [19:0] CODE_MOD = 20'd1000000;

    // Reciprocal of the code modulus, scaled by 2^51, rounded up
    localparam logic [31:0] CODE_RECIP = 32'd2251799814;

    // Default depth of the job queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // HMAC pads
    localparam logic [7:0] IPAD = 8'h36;
    localparam logic [7:0] OPAD = 8'h5c;

    // SHA-1 initial chaining value
    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hc3d2e1f0;

    // SHA-1 round constants
    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;

    // Message lengths in bits of the inner and outer hashes
    localparam logic [63:0] INNER_BITS = 64'd576;
    localparam logic [63:0] OUTER_BITS = 64'd672;

    // Configuration register indexes
    localparam logic [1:0] REG_KEY_UPPER = 2'd0;
    localparam logic [1:0] REG_KEY_LOWER = 2'd1;
    localparam logic [1:0] REG_TIME_STEP = 2'd2;

    localparam logic [7:0] TIME_STEP_RST = 8'd30;

    // One job handed from front to back
    typedef struct packed {
        logic [63:0] counter;
        logic [19:0] code;
    } hotc_job_t;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } hotc_q_stat_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_TRUNC,
        ST_MOD,
        ST_DONE
    } hotc_state_t;

endpackage

[rtl/hotc_if.sv]
interface hotc_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [63:0] moving_value;
    logic [19:0] code;

    modport source (output valid, kind, moving_value, code, input ready);
    modport sink   (input valid, kind, moving_value, code, output ready);
endinterface

interface hotc_out_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [19:0] expected_code;

    modport source (output valid, valid_res, expected_code, input ready);
    modport sink   (input valid, valid_res, expected_code, output ready);
endinterface

[rtl/hotc_front.sv]
module hotc_front (
    input  logic                  clk,
    input  logic                  rst_n,
    hotc_in_if.sink               in_ch,
    input  logic [7:0]            time_step,
    input  hotc_pkg::hotc_q_stat_t q_stat,
    output logic                  push,
    output hotc_pkg::hotc_job_t   push_job
);
    import hotc_pkg::*;

    localparam logic [6:0] DIV_STEPS = 7'd64;

    logic        hold_valid_reg;
    logic [6:0]  cnt_reg;
    logic [63:0] q_reg;
    logic [7:0]  r_reg;
    logic [7:0]  div_reg;
    logic [19:0] code_reg;

    logic        accept;
    logic [8:0]  trial;
    logic        ge;
    logic [8:0]  diff;

    // Push once any division is complete and the queue has room
    assign push   = hold_valid_reg && (cnt_reg == 7'd0) && !q_stat.full;
    assign accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = !hold_valid_reg || push;

    assign push_job.counter = q_reg;
    assign push_job.code    = code_reg;

    // One quotient bit per cycle
    assign trial = {r_reg, q_reg[63]};
    assign ge    = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};

    // Track whether the holding stage is occupied
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            cnt_reg        <= 7'd0;
        end
        else if (accept)
        begin
            hold_valid_reg <= 1'b1;
            cnt_reg        <= in_ch.kind ? DIV_STEPS : 7'd0;
        end
        else
        begin
            if (push)
                hold_valid_reg <= 1'b0;
            if (cnt_reg != 7'd0)
                cnt_reg <= cnt_reg - 7'd1;
        end
    end

    // Capture the item and advance the division
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg    <= in_ch.moving_value;
            r_reg    <= 8'd0;
            div_reg  <= (time_step == 8'd0) ? 8'd1 : time_step;
            code_reg <= in_ch.code;
        end
        else if (cnt_reg != 7'd0)
        begin
            q_reg <= {q_reg[62:0], ge};
            r_reg <= ge ? diff[7:0] : trial[7:0];
        end
    end

endmodule

[rtl/hotc_queue.sv]
module hotc_queue #(
    parameter int DEPTH = hotc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  hotc_pkg::hotc_job_t    push_job,
    input  logic                   pop,
    output hotc_pkg::hotc_job_t    pop_job,
    output hotc_pkg::hotc_q_stat_t q_stat
);
    import hotc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hotc_job_t          mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == CNT_W'(0));
    assign pop_job      = mem[rd_ptr_reg];

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    // Move pointers and the fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

[rtl/hotc_core.sv]
module hotc_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [63:0]            key_upper,
    input  logic [15:0]            key_lower,
    input  hotc_pkg::hotc_q_stat_t q_stat,
    input  hotc_pkg::hotc_job_t    pop_job,
    output logic                   pop,
    hotc_out_if.source             out_ch
);
    import hotc_pkg::*;

    hotc_state_t state_reg, state_next;

    logic [63:0]  counter_reg;
    logic [19:0]  code_reg;
    logic [1:0]   blk_reg;
    logic [6:0]   cnt_reg;
    logic [31:0]  w_reg [16];
    logic [31:0]  h_reg [5];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [159:0] inner_reg;
    logic [30:0]  bin_reg;
    logic [11:0]  quo_reg;
    logic [19:0]  rem_reg;
    logic         out_valid_reg;
    logic         res_reg;
    logic [19:0]  exp_reg;

    logic [511:0] key_blk;
    logic [511:0] blk;
    logic [31:0]  f;
    logic [31:0]  k;
    logic [31:0]  t;
    logic [31:0]  w_x;
    logic [31:0]  w_new;
    logic [159:0] digest;
    logic [159:0] dig_sh;
    logic [62:0]  prod;
    logic [30:0]  rem_full;
    logic         out_free;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign pop      = (state_reg == ST_IDLE) && !q_stat.empty;

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.valid_res     = res_reg;
    assign out_ch.expected_code = exp_reg;

    // Select the message block for this compression
    assign key_blk = {key_upper, key_lower, 432'd0};
    always_comb
    begin
        case (blk_reg)
            2'd0:    blk = key_blk ^ {64{IPAD}};
            2'd1:    blk = {counter_reg, 8'h80, 376'd0, INNER_BITS};
            2'd2:    blk = key_blk ^ {64{OPAD}};
            default: blk = {inner_reg, 8'h80, 280'd0, OUTER_BITS};
        endcase
    end

    // Round function
    always_comb
    begin
        if (cnt_reg < 7'd20)
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = K0;
        end
        else if (cnt_reg < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = K1;
        end
        else if (cnt_reg < 7'd60)
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = K2;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = K3;
        end
    end

    assign t = {a_reg[26:0], a_reg[31:27]} + f + e_reg + k + w_reg[0];

    assign w_x   = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    assign w_new = {w_x[30:0], w_x[31]};

    // Dynamic truncation picks four bytes at the offset in the last nibble
    assign digest = {h_reg[0], h_reg[1], h_reg[2], h_reg[3], h_reg[4]};
    assign dig_sh = digest << {h_reg[4][3:0], 3'b000};

    // Reduce by reciprocal multiplication: quotient first, remainder next cycle
    assign prod     = {32'd0, bin_reg} * {31'd0, CODE_RECIP};
    assign rem_full = bin_reg - ({19'd0, quo_reg} * {11'd0, CODE_MOD});

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (!q_stat.empty) state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_ROUND;
            ST_ROUND: if (cnt_reg == 7'd79) state_next = ST_ADD;
            ST_ADD:   state_next = (blk_reg == 2'd3) ? ST_TRUNC : ST_LOAD;
            ST_TRUNC: state_next = ST_MOD;
            ST_MOD:   if (cnt_reg == 7'd0) state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Hold the result until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == ST_DONE && out_free)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                counter_reg <= pop_job.counter;
                code_reg    <= pop_job.code;
                blk_reg     <= 2'd0;
            end
            ST_LOAD:
            begin
                for (int i = 0; i < 16; i++)
                    w_reg[i] <= blk[511 - 32*i -: 32];
                if (!blk_reg[0])
                begin
                    h_reg[0] <= IV0; h_reg[1] <= IV1; h_reg[2] <= IV2;
                    h_reg[3] <= IV3; h_reg[4] <= IV4;
                    a_reg <= IV0; b_reg <= IV1; c_reg <= IV2; d_reg <= IV3; e_reg <= IV4;
                end
                else
                begin
                    a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
                    d_reg <= h_reg[3]; e_reg <= h_reg[4];
                end
                cnt_reg <= 7'd0;
            end
            ST_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                    w_reg[i] <= w_reg[i+1];
                w_reg[15] <= w_new;
                e_reg <= d_reg;
                d_reg <= c_reg;
                c_reg <= {b_reg[1:0], b_reg[31:2]};
                b_reg <= a_reg;
                a_reg <= t;
                cnt_reg <= cnt_reg + 7'd1;
            end
            ST_ADD:
            begin
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
                h_reg[4] <= h_reg[4] + e_reg;
                if (blk_reg == 2'd1)
                    inner_reg <= {h_reg[0] + a_reg, h_reg[1] + b_reg, h_reg[2] + c_reg,
                                  h_reg[3] + d_reg, h_reg[4] + e_reg};
                blk_reg <= blk_reg + 2'd1;
            end
            ST_TRUNC:
            begin
                bin_reg <= dig_sh[158:128];
                cnt_reg <= 7'd1;
            end
            ST_MOD:
            begin
                if (cnt_reg == 7'd1)
                    quo_reg <= prod[62:51];
                else
                    rem_reg <= rem_full[19:0];
                cnt_reg <= cnt_reg - 7'd1;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    res_reg <= (code_reg == rem_reg);
                    exp_reg <= rem_reg;
                end
            end
            default:
            begin
                blk_reg <= 2'd0;
            end
        endcase
    end

endmodule

[rtl/hotc_if_dummy_guard.sv]
module hotc_cfg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output logic [63:0] key_upper,
    output logic [15:0] key_lower,
    output logic [7:0]  time_step
);
    import hotc_pkg::*;

    logic [63:0] key_upper_reg;
    logic [15:0] key_lower_reg;
    logic [7:0]  time_step_reg;

    assign key_upper = key_upper_reg;
    assign key_lower = key_lower_reg;
    assign time_step = time_step_reg;

    // Write registers; drop writes to unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_upper_reg <= 64'd0;
            key_lower_reg <= 16'd0;
            time_step_reg <= TIME_STEP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_UPPER: key_upper_reg <= cfg_data;
                REG_KEY_LOWER: key_lower_reg <= cfg_data[15:0];
                REG_TIME_STEP: time_step_reg <= cfg_data[7:0];
                default:       ;
            endcase
        end
    end

endmodule

[rtl/hotp_totp_code_check_top.sv]
// Channel   Dir  Payload                          Transfer
// in_ch     in   kind, moving_value, code         valid && ready
// out_ch    out  valid_res, expected_code         valid && ready
// cfg       in   cfg_index, cfg_data              cfg_we
//
// Per item, the back end runs four SHA-1 compressions (one round per cycle),
// then truncation and a reduction by reciprocal multiplication.
// Time-based items also pass through the front-end divider, which
// overlaps with the back end through the job queue.
// Reset clears control state and loads the register defaults.
// A stalled result waits in the output register; the back end then holds.
module hotp_totp_code_check_top #(
    parameter int QUEUE_DEPTH = hotc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    hotc_in_if.sink     in_ch,
    hotc_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import hotc_pkg::*;

    logic [63:0]  key_upper;
    logic [15:0]  key_lower;
    logic [7:0]   time_step;
    logic         push;
    logic         pop;
    hotc_job_t    push_job;
    hotc_job_t    pop_job;
    hotc_q_stat_t q_stat;

    hotc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key_upper (key_upper),
        .key_lower (key_lower),
        .time_step (time_step)
    );

    hotc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .time_step (time_step),
        .q_stat    (q_stat),
        .push      (push),
        .push_job  (push_job)
    );

    hotc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_stat   (q_stat)
    );

    hotc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_upper (key_upper),
        .key_lower (key_lower),
        .q_stat    (q_stat),
        .pop_job   (pop_job),
        .pop       (pop),
        .out_ch    (out_ch)
    );

endmodule

[dv/hotp_totp_code_check_top_tb.sv]
`timescale 1ns / 1ps

module hotp_totp_code_check_top_tb;
    import hotc_pkg::*;

    typedef enum logic
    {
        KIND_COUNTER = 1'b0,
        KIND_TIME    = 1'b1
    } check_kind_t;

    // Index with no register behind it; writes to it are dropped
    localparam logic [1:0] REG_NONE = 2'd3;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic        match;
        logic [19:0] code;
    } otp_verdict_t;

    logic clk;
    logic rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    hotc_in_if  in_ch ();
    hotc_out_if out_ch ();

    hotp_totp_code_check_top u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the key and window registers
    logic [63:0] key_hi;
    logic [15:0] key_lo;
    logic [7:0]  window_secs;

    otp_verdict_t pending_verdicts[$];
    int mismatches;
    int checked;
    int sent;
    int matches_seen;
    bit in_idle_on;
    bit out_idle_on;
    int out_hold;

    always #5 clk = ~clk;

    // One SHA-1 compression of a 512-bit block
    function automatic logic [159:0] sha1_compress(input logic [159:0] hv,
                                                   input logic [511:0] blk);
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = blk[511 - 32 * i -: 32];
        for (int i = 16; i < 80; i++)
        begin
            t = w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16];
            w[i] = {t[30:0], t[31]};
        end
        a = hv[159:128]; b = hv[127:96]; c = hv[95:64]; d = hv[63:32]; e = hv[31:0];
        for (int i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (b & c) | (~b & d); k = K0;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d; k = K1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d); k = K2;
            end
            else
            begin
                f = b ^ c ^ d; k = K3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[i];
            e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
        end
        return {hv[159:128] + a, hv[127:96] + b, hv[95:64] + c, hv[63:32] + d,
                hv[31:0] + e};
    endfunction

    // HMAC-SHA1 of the counter, truncated and reduced to six digits
    function automatic logic [19:0] otp_code(input check_kind_t kind,
                                             input logic [63:0] moving);
        logic [511:0] key_blk;
        logic [159:0] iv;
        logic [159:0] inner;
        logic [159:0] outer;
        logic [63:0]  counter;
        logic [63:0]  divisor;
        logic [31:0]  bin;
        logic [3:0]   off;
        iv = {IV0, IV1, IV2, IV3, IV4};
        key_blk = {key_hi, key_lo, 432'b0};
        divisor = (window_secs == 8'd0) ? 64'd1 : {56'd0, window_secs};
        counter = (kind == KIND_TIME) ? moving / divisor : moving;
        inner = sha1_compress(iv, key_blk ^ {64{IPAD}});
        inner = sha1_compress(inner, {counter, 8'h80, 376'b0, INNER_BITS});
        outer = sha1_compress(iv, key_blk ^ {64{OPAD}});
        outer = sha1_compress(outer, {inner, 8'h80, 280'b0, OUTER_BITS});
        off = outer[3:0];
        bin = outer[159 - 8 * off -: 32];
        bin[31] = 1'b0;
        return 20'(bin % 32'd1000000);
    endfunction

    // Hold a register write for one edge and mirror it
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_KEY_UPPER: key_hi = data;
            REG_KEY_LOWER: key_lo = data[15:0];
            REG_TIME_STEP: window_secs = data[7:0];
            default: ;
        endcase
    endtask

    // Present one check and wait for its transfer
    task automatic send_check(input check_kind_t kind, input logic [63:0] moving,
                              input logic [19:0] cand);
        otp_verdict_t v;
        int gap;
        v.code  = otp_code(kind, moving);
        v.match = (cand == v.code);
        pending_verdicts.push_back(v);
        gap = in_idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.kind         <= kind;
        in_ch.moving_value <= moving;
        in_ch.code         <= cand;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sent++;
    endtask

    // Let every result arrive, then give the back end time to settle
    task automatic drain();
        if (sent > 0)
            in_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Pick a candidate: often the right one, sometimes out of range
    function automatic logic [19:0] pick_code(input check_kind_t kind,
                                              input logic [63:0] moving);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return otp_code(kind, moving);
        else if (sel < 8)
            return 20'($urandom_range(0, 999999));
        else
            return 20'($urandom);
    endfunction

    // Extremes of the fields under the reset key and window
    task automatic test_directed();
        logic [19:0] c;
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        send_check(KIND_COUNTER, 64'd0, 20'd0);
        send_check(KIND_COUNTER, 64'd1, 20'd999999);
        send_check(KIND_COUNTER, '1, 20'hfffff);
        send_check(KIND_TIME, 64'd0, 20'd0);
        send_check(KIND_TIME, 64'd29, 20'd1000000);
        send_check(KIND_TIME, 64'd30, 20'd123456);
        send_check(KIND_TIME, '1, 20'd0);
        c = otp_code(KIND_COUNTER, 64'd7);
        send_check(KIND_COUNTER, 64'd7, c);
        c = otp_code(KIND_TIME, 64'h8000_0000_0000_0000);
        send_check(KIND_TIME, 64'h8000_0000_0000_0000, c);
        // The right code plus 10^6, wrapped at 20 bits, must still miss
        c = otp_code(KIND_COUNTER, 64'd9);
        send_check(KIND_COUNTER, 64'd9, c + 20'd1000000);
        drain();
    endtask

    // Key and window extremes, the zero window, and a write to no register
    task automatic test_config_extremes();
        logic [19:0] c;
        write_reg(REG_KEY_UPPER, '1);
        write_reg(REG_KEY_LOWER, 64'hffff_ffff_ffff_ffff);
        write_reg(REG_TIME_STEP, 64'hffff_ffff_ffff_ff01);
        send_check(KIND_TIME, '1, 20'd0);
        send_check(KIND_COUNTER, 64'd0, 20'd999999);
        drain();
        write_reg(REG_TIME_STEP, 64'd255);
        send_check(KIND_TIME, 64'd254, 20'd5);
        send_check(KIND_TIME, 64'd255, 20'd5);
        drain();
        // Zero window: counter is the moving value itself
        write_reg(REG_TIME_STEP, 64'd0);
        write_reg(REG_KEY_UPPER, 64'h3132_3334_3536_3738);
        write_reg(REG_KEY_LOWER, 64'h3930);
        c = otp_code(KIND_TIME, 64'd59);
        send_check(KIND_TIME, 64'd59, c);
        send_check(KIND_TIME, '1, 20'd0);
        drain();
        write_reg(REG_NONE, '1);
        send_check(KIND_TIME, 64'd1234567, 20'd0);
        drain();
        write_reg(REG_KEY_UPPER, 64'd0);
        write_reg(REG_KEY_LOWER, 64'd0);
        write_reg(REG_TIME_STEP, 64'd1);
        send_check(KIND_TIME, 64'd77, 20'd77);
        send_check(KIND_COUNTER, 64'd77, 20'd77);
        drain();
    endtask

    // Random checks over several key and window settings
    task automatic test_random(input int phases, input int per_phase);
        check_kind_t kind;
        logic [63:0] moving;
        int sel;
        for (int p = 0; p < phases; p++)
        begin
            write_reg(REG_KEY_UPPER, (p == 1) ? '1 : rand64());
            write_reg(REG_KEY_LOWER, 64'($urandom));
            case (p)
                0: write_reg(REG_TIME_STEP, 64'd1);
                1: write_reg(REG_TIME_STEP, 64'd255);
                2: write_reg(REG_TIME_STEP, 64'd0);
                3: write_reg(REG_TIME_STEP, 64'd30);
                default: write_reg(REG_TIME_STEP, 64'($urandom));
            endcase
            // Alternate stretches with and without idling on both sides
            for (int i = 0; i < per_phase; i++)
            begin
                if (i % 50 == 0)
                begin
                    in_idle_on  = ($urandom_range(0, 3) != 0);
                    out_idle_on = ($urandom_range(0, 3) != 0);
                end
                kind = check_kind_t'($urandom_range(0, 1));
                sel = $urandom_range(0, 9);
                if (sel < 2)
                    moving = 64'($urandom_range(0, 1000));
                else if (sel < 3)
                    moving = ~64'($urandom_range(0, 1000));
                else
                    moving = rand64();
                send_check(kind, moving, pick_code(kind, moving));
            end
            drain();
        end
    endtask

    // Result-side stall: a fresh hold is drawn after every transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_hold     <= 0;
        end
        else if (out_ch.valid && out_ch.ready)
        begin
            automatic int n = out_idle_on ? $urandom_range(0, 11) : 0;
            out_hold     <= n;
            out_ch.ready <= (n == 0);
        end
        else if (out_hold > 0)
        begin
            out_hold     <= out_hold - 1;
            out_ch.ready <= (out_hold == 1);
        end
        else
        begin
            out_ch.ready <= 1'b1;
        end
    end

    // Compare each transfer with the oldest pending verdict
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] unexpected result: match=%0b code=%0d", $realtime,
                             out_ch.valid_res, out_ch.expected_code);
            end
            else
            begin
                automatic otp_verdict_t v = pending_verdicts.pop_front();
                checked++;
                if (out_ch.valid_res)
                    matches_seen++;
                if (out_ch.valid_res !== v.match || out_ch.expected_code !== v.code)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"[%0t] result %0d: expected match=%0b code=%0d, ",
                                  "got match=%0b code=%0d"},
                                 $realtime, checked, v.match, v.code,
                                 out_ch.valid_res, out_ch.expected_code);
                end
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("timeout with %0d results outstanding", pending_verdicts.size());
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_KEY_UPPER;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_COUNTER;
        in_ch.moving_value = '0;
        in_ch.code = '0;
        key_hi = '0;
        key_lo = '0;
        window_secs = TIME_STEP_RST;
        mismatches = 0;
        checked = 0;
        sent = 0;
        matches_seen = 0;
        in_idle_on = 1'b0;
        out_idle_on = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_extremes();
        test_random(6, 220);

        if (pending_verdicts.size() != 0)
            mismatches++;
        $display("Checked %0d results from %0d checks, %0d of them matching codes,",
                 checked, sent, matches_seen);
        $display("over key, window and zero-window settings; %0d mismatches.", mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/hotc_pkg.sv
rtl/hotc_if.sv
rtl/hotc_front.sv
rtl/hotc_queue.sv
rtl/hotc_core.sv
rtl/hotc_if_dummy_guard.sv
rtl/hotp_totp_code_check_top.sv
dv/hotp_totp_code_check_top_tb.sv
